// ===== src/ppt_pkg.sv =====
// Shared types and sizing constants for the periodic priority task picker.
// No dependencies; used by every module of the block.
package ppt_pkg;

  localparam int TABLE_SLOTS = 8;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int IDX_W       = 3;
  localparam int TICK_W      = 32;
  localparam int PRIO_W      = 8;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_SCHED = 1'b1;

  // table write request: add goes to the next free slot, update rewrites a last run
  typedef struct packed {
    logic              add_en;
    logic              upd_en;
    logic [SLOT_W-1:0] upd_slot;
    logic [TICK_W-1:0] period;
    logic [PRIO_W-1:0] prio;
    logic [TICK_W-1:0] tick;
  } tbl_wr_t;

  // verdict of the shared compare unit for one slot
  typedef struct packed {
    logic due;
    logic better;
  } cmp_t;

endpackage

// ===== src/ppt_table.sv =====
// Task table: period, priority and last-run tick per slot, plus the fill count.
// Depends on ppt_pkg.
module ppt_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ppt_pkg::tbl_wr_t           wr,
  input  logic [ppt_pkg::SLOT_W-1:0] rd_slot,
  output logic [ppt_pkg::TICK_W-1:0] rd_period,
  output logic [ppt_pkg::PRIO_W-1:0] rd_prio,
  output logic [ppt_pkg::TICK_W-1:0] rd_last,
  output logic [ppt_pkg::CNT_W-1:0]  count
);

  logic [ppt_pkg::TICK_W-1:0] period_r [ppt_pkg::TABLE_SLOTS];
  logic [ppt_pkg::PRIO_W-1:0] prio_r   [ppt_pkg::TABLE_SLOTS];
  logic [ppt_pkg::TICK_W-1:0] last_r   [ppt_pkg::TABLE_SLOTS];
  logic [ppt_pkg::CNT_W-1:0]  count_r;
  logic [ppt_pkg::CNT_W-1:0]  count_nxt;
  logic                       room;

  assign room = (count_r < ppt_pkg::CNT_W'(ppt_pkg::TABLE_SLOTS));

  always_comb begin
    count_nxt = count_r;
    if (wr.add_en && room) begin
      count_nxt = count_r + ppt_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // storage has no reset; only slots below the count are ever read
  always_ff @(posedge clk) begin
    if (wr.add_en && room) begin
      period_r[count_r[ppt_pkg::SLOT_W-1:0]] <= wr.period;
      prio_r[count_r[ppt_pkg::SLOT_W-1:0]]   <= wr.prio;
      last_r[count_r[ppt_pkg::SLOT_W-1:0]]   <= '0;
    end else if (wr.upd_en) begin
      last_r[wr.upd_slot] <= wr.tick;
    end
  end

  assign rd_period = period_r[rd_slot];
  assign rd_prio   = prio_r[rd_slot];
  assign rd_last   = last_r[rd_slot];
  assign count     = count_r;

endmodule

// ===== src/ppt_due_unit.sv =====
// Shared compare unit: elapsed-time due check and priority compare for one slot.
// Depends on ppt_pkg.
module ppt_due_unit (
  input  logic [ppt_pkg::TICK_W-1:0] tick,
  input  logic [ppt_pkg::TICK_W-1:0] last,
  input  logic [ppt_pkg::TICK_W-1:0] period,
  input  logic [ppt_pkg::PRIO_W-1:0] prio,
  input  logic                       have,
  input  logic [ppt_pkg::PRIO_W-1:0] best_prio,
  output ppt_pkg::cmp_t              cmp
);

  logic [ppt_pkg::TICK_W-1:0] elapsed;

  // wraps modulo 2^32 by width
  assign elapsed    = tick - last;
  assign cmp.due    = (elapsed >= period);
  // strict less-than keeps the earliest slot on a tie
  assign cmp.better = cmp.due && (!have || (prio < best_prio));

endmodule

// ===== src/periodic_priority_task_picker.sv =====
// Top level of the periodic priority task picker: request handshake, scan sequencer
// and result register. Depends on ppt_pkg, ppt_table and ppt_due_unit.
//
//  channel | dir | handshake                | payload
//  in_     | in  | in_tvalid / in_tready    | tuser: func; tdata: period, priority, tick
//  out_    | out | out_tvalid / out_tready  | tuser: add_accepted, task_found; tdata: index
//
// An add request is accepted, then the result is loaded once the output register is free.
// A schedule request on a non-empty table is accepted, then the sequencer walks the table
// one slot per cycle through the single due/priority compare unit, then loads
// the result and writes the winner's last-run tick.
// Reset (rst_n low, synchronous) empties the table and drops any pending result.
// A stalled result holds in the output register; a new request is taken in the
// cycle after the result has been loaded, even while that result still waits.
module periodic_priority_task_picker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [31:0] period_ticks, [39:32] task_priority,
                                  // [71:40] current_tick
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] task_index, [7:3] zero
  output logic [1:0]  out_tuser   // [0] add_accepted, [1] task_found
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                      state_r;
  logic [ppt_pkg::SLOT_W-1:0]  scan_r;
  logic                        have_r;
  logic [ppt_pkg::SLOT_W-1:0]  best_r;
  logic [ppt_pkg::PRIO_W-1:0]  best_prio_r;
  logic [ppt_pkg::TICK_W-1:0]  tick_r;
  logic                        res_acc_r;
  logic [ppt_pkg::IDX_W-1:0]   res_idx_r;
  logic                        out_valid_r;
  logic [ppt_pkg::IDX_W-1:0]   out_idx_r;
  logic                        out_acc_r;
  logic                        out_found_r;

  logic                        in_take;
  logic                        out_free;
  logic                        scan_last;
  logic [ppt_pkg::TICK_W-1:0]  req_period;
  logic [ppt_pkg::PRIO_W-1:0]  req_prio;
  logic [ppt_pkg::TICK_W-1:0]  req_tick;
  logic                        room;

  ppt_pkg::tbl_wr_t            tbl_wr;
  logic [ppt_pkg::TICK_W-1:0]  rd_period;
  logic [ppt_pkg::PRIO_W-1:0]  rd_prio;
  logic [ppt_pkg::TICK_W-1:0]  rd_last;
  logic [ppt_pkg::CNT_W-1:0]   count;
  ppt_pkg::cmp_t               cmp;

  assign req_period = in_tdata[31:0];
  assign req_prio   = in_tdata[39:32];
  assign req_tick   = in_tdata[71:40];

  assign in_tready = (state_r == S_IDLE);
  assign in_take   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign room      = (count < ppt_pkg::CNT_W'(ppt_pkg::TABLE_SLOTS));
  assign scan_last = ((ppt_pkg::CNT_W'(scan_r) + ppt_pkg::CNT_W'(1)) == count);

  // adds are written at accept when there is room; the winner's last run is written as the result is loaded
  always_comb begin
    tbl_wr.add_en   = in_take && (in_tuser == ppt_pkg::FUNC_ADD);
    tbl_wr.upd_en   = (state_r == S_DONE) && out_free && have_r;
    tbl_wr.upd_slot = best_r;
    tbl_wr.period   = req_period;
    tbl_wr.prio     = req_prio;
    tbl_wr.tick     = tick_r;
  end

  ppt_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .rd_slot  (scan_r),
    .rd_period(rd_period),
    .rd_prio  (rd_prio),
    .rd_last  (rd_last),
    .count    (count)
  );

  ppt_due_unit u_due (
    .tick     (tick_r),
    .last     (rd_last),
    .period   (rd_period),
    .prio     (rd_prio),
    .have     (have_r),
    .best_prio(best_prio_r),
    .cmp      (cmp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      scan_r      <= '0;
    end else begin
      // a finished request reloads the register itself in S_DONE
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            tick_r <= req_tick;
            have_r <= 1'b0;
            scan_r <= '0;
            if (in_tuser == ppt_pkg::FUNC_ADD) begin
              res_acc_r   <= room;
              res_idx_r   <= room ? ppt_pkg::IDX_W'(count) : '0;
              state_r     <= S_DONE;
            end else if (count == '0) begin
              // empty table: nothing can be due
              res_acc_r   <= 1'b0;
              res_idx_r   <= '0;
              state_r     <= S_DONE;
            end else begin
              res_acc_r <= 1'b0;
              state_r   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cmp.better) begin
            have_r      <= 1'b1;
            best_r      <= scan_r;
            best_prio_r <= rd_prio;
          end
          if (scan_last) begin
            state_r <= S_DONE;
          end else begin
            scan_r <= scan_r + ppt_pkg::SLOT_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (res_acc_r) begin
              out_acc_r   <= 1'b1;
              out_found_r <= 1'b0;
              out_idx_r   <= res_idx_r;
            end else begin
              // schedule or refused add; have_r is clear for the latter
              out_acc_r   <= 1'b0;
              out_found_r <= have_r;
              out_idx_r   <= have_r ? ppt_pkg::IDX_W'(best_r) : '0;
            end
            have_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - ppt_pkg::IDX_W){1'b0}}, out_idx_r};
  assign out_tuser  = {out_found_r, out_acc_r};

`ifndef ASSERT_OFF
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished request");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("add_accepted and task_found both set");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= ppt_pkg::CNT_W'(ppt_pkg::TABLE_SLOTS))
    else $error("task count beyond table size");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (ppt_pkg::CNT_W'(scan_r) < count))
    else $error("scan index past filled slots");
`endif

endmodule
